>>> rtl/rmq_pkg.sv
`timescale 1ns / 1ps

package rmq_pkg;

  localparam int IN_W  = 16;
  localparam int NUM_W = IN_W + 1;
  localparam int OUT_W = 16;

  typedef enum logic [1:0] {
    COMP_X,
    COMP_Y,
    COMP_Z,
    COMP_W
  } comp_e;

  // sideband that rides along the square root stages
  typedef struct packed {
    logic                          valid;
    logic                          bad;
    comp_e                         prin;
    logic [3:0][NUM_W-1:0]         num;
  } sq_side_t;

  // sideband that rides along the divider stages
  typedef struct packed {
    logic                          valid;
    logic                          bad;
    comp_e                         prin;
    logic [3:0]                    neg;
    logic [OUT_W-1:0]              pval;
  } div_side_t;

endpackage

>>> rtl/rmq_isqrt.sv
`timescale 1ns / 1ps

// Pipelined integer square root, one result bit per stage.
module rmq_isqrt import rmq_pkg::*; #(
  parameter int SW = 16
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [2*SW-1:0] rad_i,
  output logic [SW-1:0]   root_o
);

  logic [SW+1:0]   rem_q  [SW];
  logic [SW-1:0]   root_q [SW];
  logic [2*SW-1:0] x_q    [SW];

  for (genvar k = 0; k < SW; k++) begin : g_stage
    logic [SW+1:0]   rem_p, rem_s, trial;
    logic [SW-1:0]   root_p;
    logic [2*SW-1:0] x_p;
    logic            ge;

    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign x_p    = rad_i;
    end else begin : g_next
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign x_p    = x_q[k-1];
    end

    always_comb begin
      rem_s = {rem_p[SW-1:0], x_p[2*SW-1 -: 2]};
      trial = {root_p, 2'b01};
      ge    = (rem_s >= trial);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? (rem_s - trial) : rem_s;
        root_q[k] <= {root_p[SW-2:0], ge};
        x_q[k]    <= x_p << 2;
      end
    end
  end

  assign root_o = root_q[SW-1];

endmodule

>>> rtl/rmq_div.sv
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per stage.
module rmq_div import rmq_pkg::*; #(
  parameter int DW = 32,
  parameter int VW = 17
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] dvd_i,
  input  logic [VW-1:0] dvs_i,
  output logic [DW-1:0] quo_o
);

  logic [VW-1:0] rem_q [DW];
  logic [VW-1:0] v_q   [DW];
  logic [DW-1:0] d_q   [DW];
  logic [DW-1:0] quo_q [DW];

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic [VW-1:0] rem_p, v_p;
    logic [DW-1:0] d_p, quo_p;
    logic [VW:0]   rem_s, rem_n;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_p = '0;
      assign v_p   = dvs_i;
      assign d_p   = dvd_i;
      assign quo_p = '0;
    end else begin : g_next
      assign rem_p = rem_q[k-1];
      assign v_p   = v_q[k-1];
      assign d_p   = d_q[k-1];
      assign quo_p = quo_q[k-1];
    end

    always_comb begin
      rem_s = {rem_p, d_p[DW-1]};
      ge    = (rem_s >= {1'b0, v_p});
      rem_n = ge ? (rem_s - {1'b0, v_p}) : rem_s;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_n[VW-1:0];
        v_q[k]   <= v_p;
        d_q[k]   <= d_p << 1;
        quo_q[k] <= {quo_p[DW-2:0], ge};
      end
    end
  end

  assign quo_o = quo_q[DW-1];

endmodule

>>> rtl/rotation_matrix_to_quaternion.sv
`timescale 1ns / 1ps

// Rotation matrix to unit quaternion, Shepperd's method, fixed point.
// Input channel: nine signed matrix entries with valid_i / stall_o. Output
// channel: quat_x/y/z/w and bad_input with valid_o / stall_i. An item is
// taken on an edge with valid high and stall low.
// Pipeline: input register, branch select, SW square root stages, divider
// setup, DW divider stages, output register. With FRAC_BITS = 14 that is
// SW = 16, DW = 32. Throughput is one item per cycle while the output is
// not stalled; the root and the four quotients are each one bit per stage.
// A stalled output freezes the whole pipe; stall_o is high only while the
// output register holds an item the receiver has not taken, so nothing is
// dropped or repeated and bubbles drain while the receiver is ready.
// Reset clears all valid bits; the pipe is empty and ready after reset.
// bad_input marks a non-positive radicand; the quaternion is then all zero.
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    stall_o,
  input  logic signed [IN_W-1:0]  m00_i,
  input  logic signed [IN_W-1:0]  m01_i,
  input  logic signed [IN_W-1:0]  m02_i,
  input  logic signed [IN_W-1:0]  m10_i,
  input  logic signed [IN_W-1:0]  m11_i,
  input  logic signed [IN_W-1:0]  m12_i,
  input  logic signed [IN_W-1:0]  m20_i,
  input  logic signed [IN_W-1:0]  m21_i,
  input  logic signed [IN_W-1:0]  m22_i,
  output logic                    valid_o,
  input  logic                    stall_i,
  output logic signed [OUT_W-1:0] quat_x_o,
  output logic signed [OUT_W-1:0] quat_y_o,
  output logic signed [OUT_W-1:0] quat_z_o,
  output logic signed [OUT_W-1:0] quat_w_o,
  output logic                    bad_input_o
);

  localparam int RAD_W = ((FRAC_BITS > IN_W) ? FRAC_BITS : IN_W) + 3;
  localparam int SW    = (RAD_W + FRAC_BITS) / 2;
  localparam int XW    = 2 * SW;
  localparam int DW    = NUM_W + FRAC_BITS + 1;
  localparam int VW    = SW + 1;
  localparam int LIM_P = (FRAC_BITS >= 15) ? 32767 : (1 << FRAC_BITS);
  localparam int LIM_N = (FRAC_BITS >= 15) ? 32768 : (1 << FRAC_BITS);
  localparam logic signed [RAD_W-1:0] ONE_R = RAD_W'(1) << FRAC_BITS;

  logic en;
  assign en      = !valid_o || !stall_i;
  assign stall_o = !en;

  // stage A: input register
  logic signed [IN_W-1:0] m_q [9];
  logic                   va_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_q[0] <= m00_i; m_q[1] <= m01_i; m_q[2] <= m02_i;
      m_q[3] <= m10_i; m_q[4] <= m11_i; m_q[5] <= m12_i;
      m_q[6] <= m20_i; m_q[7] <= m21_i; m_q[8] <= m22_i;
    end
  end

  // stage B: branch select, radicand, numerators
  logic signed [RAD_W-1:0] d00, d11, d22, rad_tr, rad;
  logic signed [NUM_W-1:0] s01, s02, s12, a21, a02, a10;
  sq_side_t                side_b_d, side_b_q;
  logic [XW-1:0]           xb_d, xb_q;

  always_comb begin
    d00    = RAD_W'(m_q[0]);
    d11    = RAD_W'(m_q[4]);
    d22    = RAD_W'(m_q[8]);
    s01    = NUM_W'(m_q[1]) + NUM_W'(m_q[3]);
    s02    = NUM_W'(m_q[2]) + NUM_W'(m_q[6]);
    s12    = NUM_W'(m_q[5]) + NUM_W'(m_q[7]);
    a21    = NUM_W'(m_q[7]) - NUM_W'(m_q[5]);
    a02    = NUM_W'(m_q[2]) - NUM_W'(m_q[6]);
    a10    = NUM_W'(m_q[3]) - NUM_W'(m_q[1]);
    rad_tr = ONE_R + d00 + d11 + d22;
    side_b_d       = '0;
    side_b_d.valid = va_q;
    rad            = rad_tr;
    if (rad_tr > 0) begin
      side_b_d.prin = COMP_W;
    end else begin
      side_b_d.prin = COMP_X;
      if (m_q[4] > m_q[0]) side_b_d.prin = COMP_Y;
      if ((side_b_d.prin == COMP_X && m_q[8] > m_q[0]) ||
          (side_b_d.prin == COMP_Y && m_q[8] > m_q[4])) begin
        side_b_d.prin = COMP_Z;
      end
    end
    unique case (side_b_d.prin)
      COMP_X: begin
        rad = ONE_R + d00 - d11 - d22;
        side_b_d.num[1] = s01; side_b_d.num[2] = s02; side_b_d.num[3] = a21;
      end
      COMP_Y: begin
        rad = ONE_R - d00 + d11 - d22;
        side_b_d.num[0] = s01; side_b_d.num[2] = s12; side_b_d.num[3] = a02;
      end
      COMP_Z: begin
        rad = ONE_R - d00 - d11 + d22;
        side_b_d.num[0] = s02; side_b_d.num[1] = s12; side_b_d.num[3] = a10;
      end
      default: begin
        side_b_d.num[0] = a21; side_b_d.num[1] = a02; side_b_d.num[2] = a10;
      end
    endcase
    side_b_d.bad = (rad <= 0);
    xb_d = side_b_d.bad ? '0 : (XW'(rad[RAD_W-2:0]) << FRAC_BITS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_b_q <= '0;
    end else if (en) begin
      side_b_q <= side_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) xb_q <= xb_d;
  end

  // square root stages
  logic [SW-1:0] root;
  sq_side_t      sq_side_q [SW];

  rmq_isqrt #(.SW(SW)) u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (xb_q),
    .root_o (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SW; k++) sq_side_q[k] <= '0;
    end else if (en) begin
      sq_side_q[0] <= side_b_q;
      for (int k = 1; k < SW; k++) sq_side_q[k] <= sq_side_q[k-1];
    end
  end

  // stage C: divider setup and principal component
  sq_side_t             sq_last;
  div_side_t            side_c_d, side_c_q;
  logic [DW-1:0]        dvd_d [4];
  logic [DW-1:0]        dvd_q [4];
  logic [VW-1:0]        dvs_q;
  logic [NUM_W-1:0]     mag   [4];
  logic [SW:0]          half;

  assign sq_last = sq_side_q[SW-1];

  always_comb begin
    side_c_d.valid = sq_last.valid;
    side_c_d.bad   = sq_last.bad;
    side_c_d.prin  = sq_last.prin;
    for (int i = 0; i < 4; i++) begin
      side_c_d.neg[i] = sq_last.num[i][NUM_W-1];
      mag[i]   = side_c_d.neg[i] ? (NUM_W'(0) - sq_last.num[i]) : sq_last.num[i];
      dvd_d[i] = (DW'(mag[i]) << FRAC_BITS) + DW'(root);
    end
    half = ({1'b0, root} + (SW+1)'(1)) >> 1;
    side_c_d.pval = (half > (SW+1)'(LIM_P)) ? OUT_W'(LIM_P) : OUT_W'(half);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_c_q <= '0;
    end else if (en) begin
      side_c_q <= side_c_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) dvd_q[i] <= dvd_d[i];
      dvs_q <= {root, 1'b0};
    end
  end

  // divider stages, one per component; the principal lane is ignored
  logic [DW-1:0] quo [4];
  div_side_t     div_side_q [DW];

  for (genvar i = 0; i < 4; i++) begin : g_div
    rmq_div #(.DW(DW), .VW(VW)) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .dvd_i (dvd_q[i]),
      .dvs_i (dvs_q),
      .quo_o (quo[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DW; k++) div_side_q[k] <= '0;
    end else if (en) begin
      div_side_q[0] <= side_c_q;
      for (int k = 1; k < DW; k++) div_side_q[k] <= div_side_q[k-1];
    end
  end

  // stage D: saturate, sign, output register
  div_side_t              dl;
  logic [OUT_W:0]         om  [4];
  logic [OUT_W-1:0]       res [4];
  logic [OUT_W-1:0]       qo_q [4];
  logic                   bad_q, vo_q;

  assign dl = div_side_q[DW-1];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (dl.neg[i]) begin
        om[i] = (quo[i] > DW'(LIM_N)) ? (OUT_W+1)'(LIM_N) : (OUT_W+1)'(quo[i]);
      end else begin
        om[i] = (quo[i] > DW'(LIM_P)) ? (OUT_W+1)'(LIM_P) : (OUT_W+1)'(quo[i]);
      end
      if (dl.bad) begin
        res[i] = '0;
      end else if (comp_e'(i) == dl.prin) begin
        res[i] = dl.pval;
      end else begin
        res[i] = dl.neg[i] ? OUT_W'((OUT_W+1)'(0) - om[i]) : OUT_W'(om[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en) begin
      vo_q <= dl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) qo_q[i] <= res[i];
      bad_q <= dl.bad;
    end
  end

  assign valid_o     = vo_q;
  assign quat_x_o    = qo_q[0];
  assign quat_y_o    = qo_q[1];
  assign quat_z_o    = qo_q[2];
  assign quat_w_o    = qo_q[3];
  assign bad_input_o = bad_q;

  // checks
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (valid_o && stall_i))
    else $error("input stalled while output register free");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && bad_input_o) |->
      (quat_x_o == '0 && quat_y_o == '0 && quat_z_o == '0 && quat_w_o == '0))
    else $error("bad input item carries a nonzero quaternion");

  a_w_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ($signed(quat_w_o) <= $signed(OUT_W'(LIM_P)) &&
                 $signed(quat_x_o) <= $signed(OUT_W'(LIM_P))))
    else $error("component exceeds saturation limit");

endmodule
